// ----- rtl/rmnh_pkg.sv -----
// Shared types, constants and the multiply-accumulate microprogram
// for the ray/mesh nearest-hit block. No dependencies.
package rmnh_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int ID_BITS_DEF    = 16;
    localparam int DIR_W          = 16;
    localparam int TOL_W          = 16;
    localparam int DIST_W         = 26;
    localparam int FRAC_SHIFT     = 14;
    localparam int CFG_IDX_W      = 3;
    localparam int STEP_W         = 6;
    localparam int GROUP_OPS      = 6;
    localparam int CROSS_OPS      = 2 * GROUP_OPS;
    localparam int NUM_MUL_OPS    = CROSS_OPS + 4 * GROUP_OPS;
    localparam int DIV_STEPS      = DIST_W + 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORG_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORG_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORG_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL   = 3'd7;

    // operand vectors: N = -dir, E1 = B-A, E2 = C-A, S = O-A
    localparam logic [1:0] V_N  = 2'd0;
    localparam logic [1:0] V_E1 = 2'd1;
    localparam logic [1:0] V_E2 = 2'd2;
    localparam logic [1:0] V_S  = 2'd3;

    // determinant slots
    localparam logic [1:0] DET_D = 2'd0;
    localparam logic [1:0] DET_T = 2'd1;
    localparam logic [1:0] DET_A = 2'd2;
    localparam logic [1:0] DET_B = 2'd3;

    typedef enum logic [1:0] {A_VEC, A_XHI, A_XLO} a_kind_t;
    typedef enum logic [1:0] {DST_NONE, DST_CROSS, DST_DET} dst_kind_t;

    typedef struct packed {
        a_kind_t   a_kind;
        logic [1:0] a_vec;
        logic       a_x;
        logic [1:0] a_comp;
        logic [1:0] b_vec;
        logic [1:0] b_comp;
        logic       shift;
        logic       neg;
        logic       first;
        dst_kind_t  dst_kind;
        logic       dst_x;
        logic [1:0] dst_c;
        logic [1:0] dst_d;
    } rmnh_op_t;

    typedef struct packed {
        logic              capture;
        logic              mul_go;
        logic [STEP_W-1:0] step;
        logic              eval1;
        logic              eval2;
        logic              div_go;
        logic              update;
        logic              emit;
    } rmnh_cmd_t;

    typedef struct packed {
        logic cand;
        logic last;
        logic out_busy;
    } rmnh_sts_t;

    function automatic logic [1:0] next3(input logic [1:0] c);
        next3 = (c == 2'd2) ? 2'd0 : c + 2'd1;
    endfunction

    // Steps 0..11: C1 = E1 x E2, C2 = N x S (two products per component).
    // Steps 12..35: D = N.C1, Dt = S.C1, Da = E2.C2, Db = -E1.C2, each
    // cross component split into a high part (shifted) and a low part.
    function automatic rmnh_op_t op_decode(input logic [STEP_W-1:0] step);
        rmnh_op_t          op;
        logic [STEP_W-1:0] k;
        logic [1:0]        c;
        logic [1:0]        c1;
        logic [1:0]        c2;
        logic              grp;
        logic [1:0]        det;
        op  = '0;
        k   = '0;
        det = DET_D;
        if (step < STEP_W'(CROSS_OPS))
        begin
            grp = (step >= STEP_W'(GROUP_OPS));
            k   = grp ? step - STEP_W'(GROUP_OPS) : step;
            c   = k[2:1];
            c1  = next3(c);
            c2  = next3(c1);
            op.a_kind = A_VEC;
            op.a_vec  = grp ? V_N : V_E1;
            op.b_vec  = grp ? V_S : V_E2;
            if (!k[0])
            begin
                op.a_comp = c1;
                op.b_comp = c2;
                op.first  = 1'b1;
            end
            else
            begin
                op.a_comp   = c2;
                op.b_comp   = c1;
                op.neg      = 1'b1;
                op.dst_kind = DST_CROSS;
                op.dst_x    = grp;
                op.dst_c    = c;
            end
        end
        else
        begin
            k = step - STEP_W'(CROSS_OPS);
            if (k < STEP_W'(GROUP_OPS))
            begin
                det = DET_D;
            end
            else if (k < STEP_W'(2 * GROUP_OPS))
            begin
                det = DET_T;
                k   = k - STEP_W'(GROUP_OPS);
            end
            else if (k < STEP_W'(3 * GROUP_OPS))
            begin
                det = DET_A;
                k   = k - STEP_W'(2 * GROUP_OPS);
            end
            else
            begin
                det = DET_B;
                k   = k - STEP_W'(3 * GROUP_OPS);
            end
            c = k[2:1];
            op.a_kind = k[0] ? A_XLO : A_XHI;
            op.shift  = !k[0];
            op.a_x    = det[1];
            op.a_comp = c;
            op.b_comp = c;
            case (det)
                DET_D:   op.b_vec = V_N;
                DET_T:   op.b_vec = V_S;
                DET_A:   op.b_vec = V_E2;
                default: op.b_vec = V_E1;
            endcase
            op.neg   = (det == DET_B);
            op.first = (k == '0);
            if (k == STEP_W'(GROUP_OPS - 1))
            begin
                op.dst_kind = DST_DET;
                op.dst_d    = det;
            end
        end
        return op;
    endfunction

endpackage

// ----- rtl/ray_mesh_nearest_hit.sv -----
// Top level of the ray/mesh nearest-hit block: sequencer plus datapath.
// Depends on rmnh_pkg, rmnh_ctrl and rmnh_dp.
//
// A triangle runs through the multiply program (36 multiply steps on the one
// shared multiplier), a drain, the hit-test states and finish; a hit adds 27
// divider steps and an update before finish. The block takes a new triangle
// only once it is through with the last. The last triangle's result is valid
// as the block turns ready; for the last triangle of a mesh, finish holds while
// an earlier result still waits. Reset (async, active low) restores config
// defaults and clears the kept hit and the output valid.
module ray_mesh_nearest_hit
    import rmnh_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int ID_BITS    = ID_BITS_DEF,
    parameter int CFG_W      = (COORD_BITS > DIR_W) ? COORD_BITS : DIR_W
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration writes
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]             cfg_data,
    // triangle stream
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] a_x,
    input  logic signed [COORD_BITS-1:0] a_y,
    input  logic signed [COORD_BITS-1:0] a_z,
    input  logic signed [COORD_BITS-1:0] b_x,
    input  logic signed [COORD_BITS-1:0] b_y,
    input  logic signed [COORD_BITS-1:0] b_z,
    input  logic signed [COORD_BITS-1:0] c_x,
    input  logic signed [COORD_BITS-1:0] c_y,
    input  logic signed [COORD_BITS-1:0] c_z,
    input  logic [ID_BITS-1:0]           tri_id,
    input  logic                         last_tri,
    // result, one transfer per mesh
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         hit_found,
    output logic [DIST_W-1:0]            hit_distance,
    output logic [ID_BITS-1:0]           hit_tri_id
);

    rmnh_cmd_t cmd;
    rmnh_sts_t sts;

    // sequencer: one state per phase, step counter shared by MAC and divider
    rmnh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: triple products via two cross products then dot products,
    // tolerance tests, Dt/D divide, best-hit compare, result register
    rmnh_dp #(
        .COORD_BITS (COORD_BITS),
        .ID_BITS    (ID_BITS),
        .CFG_W      (CFG_W)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .a_x          (a_x),
        .a_y          (a_y),
        .a_z          (a_z),
        .b_x          (b_x),
        .b_y          (b_y),
        .b_z          (b_z),
        .c_x          (c_x),
        .c_y          (c_y),
        .c_z          (c_z),
        .tri_id       (tri_id),
        .last_tri     (last_tri),
        .cmd          (cmd),
        .sts          (sts),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .hit_found    (hit_found),
        .hit_distance (hit_distance),
        .hit_tri_id   (hit_tri_id)
    );

endmodule

// ----- rtl/rmnh_ctrl.sv -----
// Sequencer for the nearest-hit block: walks the multiply program,
// the hit test, the serial divider and the result transfer. Uses rmnh_pkg.
module rmnh_ctrl
    import rmnh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  rmnh_sts_t sts,
    output rmnh_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_DRAIN, S_EVAL1, S_EVAL2, S_DIV, S_UPD, S_FIN
    } state_t;

    state_t            state_reg;
    logic [STEP_W-1:0] step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    step_reg <= '0;
                    if (in_valid)
                        state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    if (step_reg == STEP_W'(NUM_MUL_OPS - 1))
                        state_reg <= S_DRAIN;
                    else
                        step_reg <= step_reg + 1'b1;
                end
                S_DRAIN: state_reg <= S_EVAL1;
                S_EVAL1: state_reg <= S_EVAL2;
                S_EVAL2:
                begin
                    step_reg  <= '0;
                    state_reg <= sts.cand ? S_DIV : S_FIN;
                end
                S_DIV:
                begin
                    if (step_reg == STEP_W'(DIV_STEPS - 1))
                        state_reg <= S_UPD;
                    else
                        step_reg <= step_reg + 1'b1;
                end
                S_UPD: state_reg <= S_FIN;
                S_FIN:
                begin
                    if (!sts.last || !sts.out_busy)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd         = '0;
        cmd.capture = (state_reg == S_IDLE) && in_valid;
        cmd.mul_go  = (state_reg == S_MUL);
        cmd.step    = step_reg;
        cmd.eval1   = (state_reg == S_EVAL1);
        cmd.eval2   = (state_reg == S_EVAL2);
        cmd.div_go  = (state_reg == S_DIV);
        cmd.update  = (state_reg == S_UPD);
        cmd.emit    = (state_reg == S_FIN) && sts.last && !sts.out_busy;
    end

endmodule

// ----- rtl/rmnh_dp.sv -----
// Datapath: config registers, shared multiplier with accumulator,
// hit test, restoring divider, best-hit tracking, output register. Uses rmnh_pkg.
module rmnh_dp
    import rmnh_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int ID_BITS    = ID_BITS_DEF,
    parameter int CFG_W      = (COORD_BITS > DIR_W) ? COORD_BITS : DIR_W
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]             cfg_data,
    input  logic signed [COORD_BITS-1:0] a_x,
    input  logic signed [COORD_BITS-1:0] a_y,
    input  logic signed [COORD_BITS-1:0] a_z,
    input  logic signed [COORD_BITS-1:0] b_x,
    input  logic signed [COORD_BITS-1:0] b_y,
    input  logic signed [COORD_BITS-1:0] b_z,
    input  logic signed [COORD_BITS-1:0] c_x,
    input  logic signed [COORD_BITS-1:0] c_y,
    input  logic signed [COORD_BITS-1:0] c_z,
    input  logic [ID_BITS-1:0]           tri_id,
    input  logic                         last_tri,
    input  rmnh_cmd_t                    cmd,
    output rmnh_sts_t                    sts,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic                         hit_found,
    output logic [DIST_W-1:0]            hit_distance,
    output logic [ID_BITS-1:0]           hit_tri_id
);

    localparam int DW  = (COORD_BITS + 1 > DIR_W + 1) ? COORD_BITS + 1 : DIR_W + 1;
    localparam int XW  = 2 * DW + 1;
    localparam int PW  = 2 * DW + 1;
    localparam int W   = 3 * DW + 3;
    localparam int RW  = W + FRAC_SHIFT;
    localparam int DSW = W + DIST_W;
    localparam int QW  = DIST_W + 1;

    // configuration
    logic signed [COORD_BITS-1:0] org_reg [3];
    logic signed [DIR_W-1:0]      dir_reg [3];
    logic                         mode_reg;
    logic [TOL_W-1:0]             tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg[0] <= '0;
            org_reg[1] <= '0;
            org_reg[2] <= '0;
            dir_reg[0] <= '0;
            dir_reg[1] <= '0;
            dir_reg[2] <= DIR_W'(16384);
            mode_reg   <= 1'b1;
            tol_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ORG_X: org_reg[0] <= cfg_data[COORD_BITS-1:0];
                CFG_ORG_Y: org_reg[1] <= cfg_data[COORD_BITS-1:0];
                CFG_ORG_Z: org_reg[2] <= cfg_data[COORD_BITS-1:0];
                CFG_DIR_X: dir_reg[0] <= cfg_data[DIR_W-1:0];
                CFG_DIR_Y: dir_reg[1] <= cfg_data[DIR_W-1:0];
                CFG_DIR_Z: dir_reg[2] <= cfg_data[DIR_W-1:0];
                CFG_MODE:  mode_reg   <= cfg_data[0];
                CFG_TOL:   tol_reg    <= cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // operand capture
    logic signed [COORD_BITS-1:0] av [3];
    logic signed [COORD_BITS-1:0] bv [3];
    logic signed [COORD_BITS-1:0] cv [3];
    logic signed [DW-1:0]         vec_reg [4][3];
    logic [ID_BITS-1:0]           id_reg;
    logic                         last_reg;

    assign av[0] = a_x;
    assign av[1] = a_y;
    assign av[2] = a_z;
    assign bv[0] = b_x;
    assign bv[1] = b_y;
    assign bv[2] = b_z;
    assign cv[0] = c_x;
    assign cv[1] = c_y;
    assign cv[2] = c_z;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            for (int r = 0; r < 3; r++)
            begin
                vec_reg[V_N][r]  <= -DW'(dir_reg[r]);
                vec_reg[V_E1][r] <= DW'(bv[r]) - DW'(av[r]);
                vec_reg[V_E2][r] <= DW'(cv[r]) - DW'(av[r]);
                vec_reg[V_S][r]  <= DW'(org_reg[r]) - DW'(av[r]);
            end
            id_reg   <= tri_id;
            last_reg <= last_tri;
        end
    end

    // multiply stage
    rmnh_op_t             op;
    rmnh_op_t             op_d1_reg;
    logic                 acc_go_reg;
    logic signed [DW:0]   mul_a;
    logic signed [DW-1:0] mul_b;
    logic signed [PW-1:0] prod_reg;
    logic signed [XW-1:0] cross_reg [2][3];
    logic [XW-1:0]        xsel;

    assign op   = op_decode(cmd.step);
    assign xsel = cross_reg[op.a_x][op.a_comp];

    always_comb
    begin
        case (op.a_kind)
            A_VEC:   mul_a = (DW+1)'(vec_reg[op.a_vec][op.a_comp]);
            A_XHI:   mul_a = xsel[XW-1:DW];
            A_XLO:   mul_a = {1'b0, xsel[DW-1:0]};
            default: mul_a = '0;
        endcase
        mul_b = vec_reg[op.b_vec][op.b_comp];
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= mul_a * mul_b;
        op_d1_reg <= op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_go_reg <= 1'b0;
        else
            acc_go_reg <= cmd.mul_go;
    end

    // accumulate stage
    logic signed [W-1:0] term;
    logic signed [W-1:0] base;
    logic signed [W-1:0] acc_next;
    logic signed [W-1:0] acc_reg;
    logic signed [W-1:0] det_reg [4];

    always_comb
    begin
        term     = op_d1_reg.shift ? (W'(prod_reg) <<< DW) : W'(prod_reg);
        base     = op_d1_reg.first ? '0 : acc_reg;
        acc_next = op_d1_reg.neg ? base - term : base + term;
    end

    always_ff @(posedge clk)
    begin
        if (acc_go_reg)
        begin
            acc_reg <= acc_next;
            case (op_d1_reg.dst_kind)
                DST_CROSS: cross_reg[op_d1_reg.dst_x][op_d1_reg.dst_c] <= acc_next[XW-1:0];
                DST_DET:   det_reg[op_d1_reg.dst_d] <= acc_next;
                default: ;
            endcase
        end
    end

    // hit test
    logic signed [W-1:0] tol_w;
    logic signed [W:0]   tol_x;
    logic signed [W:0]   d_x;
    logic signed [W:0]   sum_reg;
    logic                dpos_reg;
    logic                dneg_reg;
    logic                ga_reg;
    logic                gb_reg;
    logic                la_reg;
    logic                lb_reg;
    logic                hi_ok;
    logic                lo_ok;
    logic                hit;
    logic                cand;
    logic [W-1:0]        dt_abs;
    logic [W-1:0]        d_abs;

    assign tol_w = W'(tol_reg);
    assign tol_x = (W+1)'(tol_reg);
    assign d_x   = (W+1)'(det_reg[DET_D]);

    always_ff @(posedge clk)
    begin
        if (cmd.eval1)
        begin
            sum_reg  <= (W+1)'(det_reg[DET_A]) + (W+1)'(det_reg[DET_B]);
            dpos_reg <= det_reg[DET_D] > tol_w;
            dneg_reg <= det_reg[DET_D] < -tol_w;
            ga_reg   <= det_reg[DET_A] > -tol_w;
            gb_reg   <= det_reg[DET_B] > -tol_w;
            la_reg   <= det_reg[DET_A] < tol_w;
            lb_reg   <= det_reg[DET_B] < tol_w;
        end
    end

    always_comb
    begin
        hi_ok  = !((d_x + tol_x) < sum_reg);
        lo_ok  = !(sum_reg < (d_x - tol_x));
        hit    = dpos_reg ? (ga_reg && gb_reg && hi_ok)
               : dneg_reg ? (la_reg && lb_reg && lo_ok) : 1'b0;
        cand   = hit && (det_reg[DET_T] != '0)
               && (det_reg[DET_T][W-1] == det_reg[DET_D][W-1]);
        dt_abs = det_reg[DET_T][W-1] ? -det_reg[DET_T] : det_reg[DET_T];
        d_abs  = det_reg[DET_D][W-1] ? -det_reg[DET_D] : det_reg[DET_D];
    end

    // restoring divider, first step checks saturation
    logic [RW-1:0]  rem_reg;
    logic [DSW-1:0] dsr_reg;
    logic [QW-1:0]  q_reg;
    logic           ge;

    assign ge = DSW'(rem_reg) >= dsr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.eval2)
        begin
            rem_reg <= RW'(dt_abs) << FRAC_SHIFT;
            dsr_reg <= DSW'(d_abs) << DIST_W;
        end
        else if (cmd.div_go)
        begin
            if (ge)
                rem_reg <= rem_reg - dsr_reg[RW-1:0];
            dsr_reg <= dsr_reg >> 1;
            q_reg   <= {q_reg[QW-2:0], ge};
        end
    end

    // best hit and result register
    logic [DIST_W-1:0]  qv;
    logic               take;
    logic               any_hit_reg;
    logic [DIST_W-1:0]  best_q_reg;
    logic [ID_BITS-1:0] best_id_reg;
    logic               out_valid_reg;

    always_comb
    begin
        qv   = q_reg[QW-1] ? '1 : q_reg[DIST_W-1:0];
        take = (qv != '0) && (!any_hit_reg ||
               (mode_reg ? (qv < best_q_reg) : (qv > best_q_reg)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
                any_hit_reg <= 1'b0;
            else if (cmd.update && take)
                any_hit_reg <= 1'b1;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update && take)
        begin
            best_q_reg  <= qv;
            best_id_reg <= id_reg;
        end
        if (cmd.emit)
        begin
            hit_found    <= any_hit_reg;
            hit_distance <= any_hit_reg ? best_q_reg : '0;
            hit_tri_id   <= any_hit_reg ? best_id_reg : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sts.cand     = cand;
    assign sts.last     = last_reg;
    assign sts.out_busy = out_valid_reg && !out_ready;

endmodule

// ----- rtl/rmnh_chk.sv -----
// Port-level checks for ray_mesh_nearest_hit, attached by bind.
// Uses rmnh_pkg.
module rmnh_chk
    import rmnh_pkg::*;
#(
    parameter int ID_BITS = ID_BITS_DEF
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               hit_found,
    input logic [DIST_W-1:0]  hit_distance,
    input logic [ID_BITS-1:0] hit_tri_id
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit_found)
        && $stable(hit_distance) && $stable(hit_tri_id))
        else $error("result changed while stalled");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit_found |-> hit_distance == '0 && hit_tri_id == '0)
        else $error("miss result carries data");

    a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit_found |-> hit_distance != '0)
        else $error("hit with zero distance");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second triangle taken while busy");

endmodule

bind ray_mesh_nearest_hit rmnh_chk #(.ID_BITS(ID_BITS)) u_rmnh_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hit_found    (hit_found),
    .hit_distance (hit_distance),
    .hit_tri_id   (hit_tri_id)
);

// ----- test/ray_mesh_nearest_hit_test.sv -----
// Testbench for ray_mesh_nearest_hit: directed meshes, then random meshes
// against an in-bench hit predictor. Depends on rmnh_pkg and the block's RTL.
module ray_mesh_nearest_hit_test;
    import rmnh_pkg::*;

    localparam int CW = COORD_BITS_DEF;
    localparam int IW = ID_BITS_DEF;
    localparam logic [DIST_W-1:0] DIST_SAT = '1;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic signed [CW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
        logic [IW-1:0]        id;
        logic                 last;
    } tri_t;

    typedef struct {
        logic              found;
        logic [DIST_W-1:0] distance;
        logic [IW-1:0]     id;
    } hit_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CW-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic signed [CW-1:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
    logic [IW-1:0] tri_id;
    logic last_tri;
    logic out_valid;
    logic out_ready;
    logic hit_found;
    logic [DIST_W-1:0] hit_distance;
    logic [IW-1:0] hit_tri_id;

    ray_mesh_nearest_hit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .a_x          (a_x),
        .a_y          (a_y),
        .a_z          (a_z),
        .b_x          (b_x),
        .b_y          (b_y),
        .b_z          (b_z),
        .c_x          (c_x),
        .c_y          (c_y),
        .c_z          (c_z),
        .tri_id       (tri_id),
        .last_tri     (last_tri),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit_found    (hit_found),
        .hit_distance (hit_distance),
        .hit_tri_id   (hit_tri_id)
    );

    // 20-unit period
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ---------------------------------------------------------------
    // Hit predictor: own copy of the ray registers and the kept hit.
    // ---------------------------------------------------------------
    logic signed [CW-1:0]    ray_org [3];
    logic signed [DIR_W-1:0] ray_dir [3];
    logic                    keep_nearest;
    logic [TOL_W-1:0]        tol;
    logic [DIST_W-1:0]       best_dist;
    logic [IW-1:0]           best_id;
    logic                    have_hit;

    hit_t expected_hits[$];

    int send_idle_pct;
    int recv_idle_pct;
    int tris_sent;
    int meshes_sent;
    int hits_seen;
    int meshes_checked;
    int errors;

    // 3x3 determinant, arguments given column by column
    function automatic wide_t det3(input wide_t p0, p1, p2, q0, q1, q2, r0, r1, r2);
        return p0 * q1 * r2 + q0 * r1 * p2 + r0 * p1 * q2
             - r0 * q1 * p2 - q0 * p1 * r2 - p0 * r1 * q2;
    endfunction

    task automatic clear_kept_hit();
        best_dist = keep_nearest ? DIST_SAT : '0;
        best_id   = '0;
        have_hit  = 1'b0;
    endtask

    // Cramer's rule on N = -dir, E1 = B-A, E2 = C-A, S = O-A
    task automatic predict_triangle(input tri_t t);
        wide_t n[3], e1[3], e2[3], s[3];
        wide_t av[3], bv[3], cv[3];
        wide_t d, dt, da, db, wt, num, den;
        logic  hit;
        logic [DIST_W-1:0] q;
        logic  take;
        hit_t  res;
        av[0] = t.ax; av[1] = t.ay; av[2] = t.az;
        bv[0] = t.bx; bv[1] = t.by; bv[2] = t.bz;
        cv[0] = t.cx; cv[1] = t.cy; cv[2] = t.cz;
        for (int r = 0; r < 3; r++)
        begin
            n[r]  = -wide_t'(ray_dir[r]);
            e1[r] = bv[r] - av[r];
            e2[r] = cv[r] - av[r];
            s[r]  = wide_t'(ray_org[r]) - av[r];
        end
        d  = det3(n[0], n[1], n[2], e1[0], e1[1], e1[2], e2[0], e2[1], e2[2]);
        dt = det3(s[0], s[1], s[2], e1[0], e1[1], e1[2], e2[0], e2[1], e2[2]);
        da = det3(n[0], n[1], n[2], s[0], s[1], s[2], e2[0], e2[1], e2[2]);
        db = det3(n[0], n[1], n[2], e1[0], e1[1], e1[2], s[0], s[1], s[2]);
        wt = wide_t'({1'b0, tol});
        hit = 1'b0;
        if (d > wt)
            hit = (da > -wt) && (db > -wt) && !(d + wt < da + db);
        else if (d < -wt)
            hit = (da < wt) && (db < wt) && !(da + db < d - wt);
        if (hit && dt != 0 && ((dt < 0) == (d < 0)))
        begin
            num = ((dt < 0) ? -dt : dt) <<< FRAC_SHIFT;
            den = (d < 0) ? -d : d;
            if (num >= (den <<< DIST_W))
                q = DIST_SAT;
            else
                q = DIST_W'(num / den);
            // a parameter that truncates to zero does not count
            if (q != 0)
            begin
                if (!have_hit)
                    take = 1'b1;
                else if (keep_nearest)
                    take = q < best_dist;
                else
                    take = q > best_dist;
                if (take)
                begin
                    best_dist = q;
                    best_id   = t.id;
                    have_hit  = 1'b1;
                end
            end
        end
        if (t.last)
        begin
            res.found    = have_hit;
            res.distance = have_hit ? best_dist : '0;
            res.id       = have_hit ? best_id : '0;
            expected_hits.push_back(res);
            clear_kept_hit();
        end
    endtask

    // ---------------------------------------------------------------
    // Result side: random back-pressure, checks at the rising edge.
    // ---------------------------------------------------------------
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        hit_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_hits.size() == 0)
            begin
                $error("result transfer with nothing expected");
                errors++;
            end
            else
            begin
                e = expected_hits.pop_front();
                meshes_checked++;
                if (hit_found)
                    hits_seen++;
                if (hit_found !== e.found)
                begin
                    $error("hit_found: expected %0d, got %0d", e.found, hit_found);
                    errors++;
                end
                if (hit_distance !== e.distance)
                begin
                    $error("hit_distance: expected %0d, got %0d", e.distance,
                           hit_distance);
                    errors++;
                end
                if (hit_tri_id !== e.id)
                begin
                    $error("hit_tri_id: expected %0d, got %0d", e.id, hit_tri_id);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CW'(val);
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_ORG_X: ray_org[0] = CW'(val);
            CFG_ORG_Y: ray_org[1] = CW'(val);
            CFG_ORG_Z: ray_org[2] = CW'(val);
            CFG_DIR_X: ray_dir[0] = val[DIR_W-1:0];
            CFG_DIR_Y: ray_dir[1] = val[DIR_W-1:0];
            CFG_DIR_Z: ray_dir[2] = val[DIR_W-1:0];
            CFG_MODE:  keep_nearest = val[0];
            default:   tol = val[TOL_W-1:0];
        endcase
    endtask

    task automatic set_ray(input int ox, oy, oz, dx, dy, dz, near, tl);
        write_reg(CFG_ORG_X, ox);
        write_reg(CFG_ORG_Y, oy);
        write_reg(CFG_ORG_Z, oz);
        write_reg(CFG_DIR_X, dx);
        write_reg(CFG_DIR_Y, dy);
        write_reg(CFG_DIR_Z, dz);
        write_reg(CFG_MODE, near);
        write_reg(CFG_TOL, tl);
    endtask

    // one triangle transfer; valid stays up into the next call
    task automatic send_tri(input tri_t t);
        int gap;
        if ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        a_x <= t.ax; a_y <= t.ay; a_z <= t.az;
        b_x <= t.bx; b_y <= t.by; b_z <= t.bz;
        c_x <= t.cx; c_y <= t.cy; c_z <= t.cz;
        tri_id   <= t.id;
        last_tri <= t.last;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_triangle(t);
        tris_sent++;
        if (t.last)
            meshes_sent++;
    endtask

    task automatic end_stream();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // wait for outstanding results, then let a rejected or hitting triangle finish
    task automatic drain();
        while (expected_hits.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic tri_t mk(input int ax, ay, az, bx, by, bz, cx, cy, cz,
                                input int id, input logic last);
        tri_t t;
        t.ax = CW'(ax); t.ay = CW'(ay); t.az = CW'(az);
        t.bx = CW'(bx); t.by = CW'(by); t.bz = CW'(bz);
        t.cx = CW'(cx); t.cy = CW'(cy); t.cz = CW'(cz);
        t.id = IW'(id);
        t.last = last;
        return t;
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // reset ray: origin 0, looking along +z, nearest mode
    task automatic test_basic_hits();
        send_tri(mk(-1000, -1000, 512, 1000, -1000, 512, 0, 1000, 512, 1, 0));
        send_tri(mk(-1000, -1000, 256, 1000, -1000, 256, 0, 1000, 256, 2, 0));
        send_tri(mk(-1000, -1000, 768, 1000, -1000, 768, 0, 1000, 768, 3, 1));
        // reversed winding flips the determinant sign
        send_tri(mk(-1000, -1000, 300, 0, 1000, 300, 1000, -1000, 300, 4, 1));
        end_stream();
        drain();
    endtask

    task automatic test_rejects();
        // plane holds the ray: zero determinant
        send_tri(mk(0, -100, 0, 0, 100, 0, 0, 0, 500, 10, 1));
        // behind the origin
        send_tri(mk(-1000, -1000, -256, 1000, -1000, -256, 0, 1000, -256, 11, 1));
        // misses to the side
        send_tri(mk(2000, 2000, 256, 3000, 2000, 256, 2500, 3000, 256, 12, 1));
        // through the origin: zero parameter
        send_tri(mk(-1000, -1000, 0, 1000, -1000, 0, 0, 1000, 0, 13, 1));
        end_stream();
        drain();
        // tiny triangles against the widest tolerance
        write_reg(CFG_TOL, 65535);
        send_tri(mk(-1, 0, 256, 1, 0, 256, 0, 1, 256, 14, 1));
        send_tri(mk(-1, -1, 256, 1, -1, 256, 0, 1, 256, 15, 1));
        end_stream();
        drain();
        write_reg(CFG_TOL, 0);
    endtask

    task automatic test_ties_and_extremes();
        send_tri(mk(-500, -500, 400, 500, -500, 400, 0, 500, 400, 5, 0));
        send_tri(mk(-500, -500, 400, 500, -500, 400, 0, 500, 400, 6, 1));
        end_stream();
        drain();
        write_reg(CFG_MODE, 0);
        send_tri(mk(-500, -500, 400, 500, -500, 400, 0, 500, 400, 7, 0));
        send_tri(mk(-500, -500, 900, 500, -500, 900, 0, 500, 900, 8, 0));
        send_tri(mk(-500, -500, 900, 500, -500, 900, 0, 500, 900, 9, 1));
        send_tri(mk(-8388608, -8388608, 8388607, 8388607, -8388608, 8388607,
                    0, 8388607, 8388607, 65535, 1));
        send_tri(mk(8388607, 8388607, -8388608, -8388608, 8388607, 8388607,
                    8388607, -8388608, 8388607, 0, 1));
        end_stream();
        drain();
        write_reg(CFG_MODE, 1);
    endtask

    // direction outside the unit range: truncation to zero and saturation
    task automatic test_param_extremes();
        write_reg(CFG_DIR_Z, 32767);
        send_tri(mk(-1000, -1000, 1, 1000, -1000, 1, 0, 1000, 1, 20, 1));
        end_stream();
        drain();
        write_reg(CFG_DIR_Z, 1);
        send_tri(mk(-1000, -1000, 8388607, 1000, -1000, 8388607, 0, 1000, 8388607,
                    21, 1));
        end_stream();
        drain();
        set_ray(-8388608, 8388607, 0, -16384, 16384, 32768, 0, 65535);
        send_tri(mk(1, 2, 3, 4, 5, 6, 7, 8, 9, 22, 1));
        end_stream();
        drain();
    endtask

    function automatic int clamp24(input longint v);
        if (v > 8388607)
            return 8388607;
        if (v < -8388608)
            return -8388608;
        return int'(v);
    endfunction

    // mostly triangles placed around a point on the ray, some pure noise
    function automatic tri_t random_tri(input logic last);
        tri_t   t;
        longint px, py, pz, tp;
        int     span;
        if ($urandom_range(99) < 12)
        begin
            t.ax = CW'($urandom); t.ay = CW'($urandom); t.az = CW'($urandom);
            t.bx = CW'($urandom); t.by = CW'($urandom); t.bz = CW'($urandom);
            t.cx = CW'($urandom); t.cy = CW'($urandom); t.cz = CW'($urandom);
        end
        else
        begin
            if ($urandom_range(0, 1))
                tp = longint'($urandom_range(1, 4000));
            else
                tp = longint'($urandom_range(1, 65535));
            if ($urandom_range(9) == 0)
                tp = -tp;
            px = ray_org[0] + ((longint'(ray_dir[0]) * tp) >>> 6);
            py = ray_org[1] + ((longint'(ray_dir[1]) * tp) >>> 6);
            pz = ray_org[2] + ((longint'(ray_dir[2]) * tp) >>> 6);
            span = $urandom_range(0, 3) == 0 ? 30 : $urandom_range(100, 60000);
            t.ax = CW'(clamp24(px + $signed($urandom_range(0, 2 * span)) - span));
            t.ay = CW'(clamp24(py + $signed($urandom_range(0, 2 * span)) - span));
            t.az = CW'(clamp24(pz + $signed($urandom_range(0, 2 * span)) - span));
            t.bx = CW'(clamp24(px + $signed($urandom_range(0, 2 * span)) - span));
            t.by = CW'(clamp24(py + $signed($urandom_range(0, 2 * span)) - span));
            t.bz = CW'(clamp24(pz + $signed($urandom_range(0, 2 * span)) - span));
            t.cx = CW'(clamp24(px + $signed($urandom_range(0, 2 * span)) - span));
            t.cy = CW'(clamp24(py + $signed($urandom_range(0, 2 * span)) - span));
            t.cz = CW'(clamp24(pz + $signed($urandom_range(0, 2 * span)) - span));
        end
        t.id   = IW'($urandom);
        t.last = last;
        return t;
    endfunction

    function automatic int random_dir();
        case ($urandom_range(4))
            0:       return 16384;
            1:       return -16384;
            2:       return 0;
            3:       return $urandom_range(0, 65535);
            default: return $signed($urandom_range(0, 32768)) - 16384;
        endcase
    endfunction

    // several ray settings, each followed by a batch of random meshes
    task automatic test_random_meshes(input int n_tris, input int s_pct, input int r_pct);
        int sent;
        int len;
        int tl;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        sent = 0;
        while (sent < n_tris)
        begin
            case ($urandom_range(3))
                0:       tl = 0;
                1:       tl = 65535;
                default: tl = $urandom_range(0, 65535);
            endcase
            if ($urandom_range(7) == 0)
                set_ray($urandom, $urandom, $urandom, random_dir(), random_dir(),
                        random_dir(), $urandom_range(0, 1), tl);
            else
                set_ray($signed($urandom_range(0, 2097152)) - 1048576,
                        $signed($urandom_range(0, 2097152)) - 1048576,
                        $signed($urandom_range(0, 2097152)) - 1048576,
                        random_dir(), random_dir(), random_dir(),
                        $urandom_range(0, 1), tl);
            for (int m = 0; m < 25; m++)
            begin
                len = $urandom_range(1, 8);
                for (int k = 0; k < len; k++)
                    send_tri(random_tri(k == len - 1));
                sent += len;
            end
            end_stream();
            drain();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        {a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} = '0;
        tri_id = '0;
        last_tri = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        tris_sent = 0;
        meshes_sent = 0;
        hits_seen = 0;
        meshes_checked = 0;
        errors = 0;
        ray_org[0] = '0; ray_org[1] = '0; ray_org[2] = '0;
        ray_dir[0] = '0; ray_dir[1] = '0; ray_dir[2] = 16'sd16384;
        keep_nearest = 1'b1;
        tol = '0;
        clear_kept_hit();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 28;
        recv_idle_pct = 54;
        test_basic_hits();
        test_rejects();
        test_ties_and_extremes();
        test_param_extremes();

        test_random_meshes(580, 28, 54);
        test_random_meshes(580, 54, 28);
        test_random_meshes(580, 0, 0);

        drain();
        $display("%0d triangles in %0d meshes, %0d results checked, %0d with a hit",
                 tris_sent, meshes_sent, meshes_checked, hits_seen);
        if (errors == 0)
            $display("[ray_mesh_nearest_hit] OK");
        else
            $display("[ray_mesh_nearest_hit] ERROR");
        $finish;
    end

    // run limit, well beyond the slowest legal run
    initial
    begin
        #60000000;
        $display("[ray_mesh_nearest_hit] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/rmnh_pkg.sv
rtl/rmnh_ctrl.sv
rtl/rmnh_dp.sv
rtl/ray_mesh_nearest_hit.sv
rtl/rmnh_chk.sv
test/ray_mesh_nearest_hit_test.sv
